// ----- rtl/core/r2fft_pkg.sv -----
// shared types and constants of the radix-2 fft engine
package r2fft_pkg;

	localparam int INNER_WIDTH = 28;
	localparam int BIN_WIDTH   = 11;
	localparam int CFG_WIDTH   = 4;

	localparam logic CFG_INVERSE = 1'b0;
	localparam logic CFG_POINTS  = 1'b1;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_READ = 1'b1;

	localparam logic PHASE_LOAD = 1'b0;
	localparam logic PHASE_READ = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_A,
		ST_RD_B,
		ST_DIFF,
		ST_MUL,
		ST_WR_B
	} st_t;

	function automatic logic signed [INNER_WIDTH-1:0] sat_inner(input logic signed [63:0] v);
		logic signed [63:0] lim;
		lim = 64'sd1 <<< (INNER_WIDTH - 1);
		if (v >= lim) begin
			return INNER_WIDTH'(lim - 64'sd1);
		end
		if (v < -lim) begin
			return INNER_WIDTH'(-lim);
		end
		return INNER_WIDTH'(v);
	endfunction

endpackage

// ----- rtl/core/r2fft_ram.sv -----
// generic single-clock ram, one write port and one registered read port
module r2fft_ram #(
	parameter int WIDTH = 56,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/core/radix2_fft_engine.sv -----
// top level of the in-place radix-2 decimation-in-frequency fft engine
// Loads (req_type 0) fill the sample store from index 0; the load that fills
// entry N-1 (N = 2^points_log2, with points_log2 held to 1..MAX_POINTS_LOG2)
// raises busy for the transform: each butterfly reads its two entries through
// the single read port of the sample ram, runs the difference and the twiddle
// multiply in registered steps and writes both entries back through the single
// write port. While busy is high start is ignored. After that, reads (req_type
// 1) return bins 0 to N-1 in natural order, one per accepted read, on out_valid
// through the rd_s1 and output registers; bit reversal and the inverse scaling
// happen on the way out. A load or read at any other time is dropped and gives
// no result. Results cannot be held off: out_valid is a one-cycle strobe. Loads
// and reads are accepted every cycle outside busy.
module radix2_fft_engine #(
	parameter int MAX_POINTS_LOG2 = 11,
	parameter int SAMPLE_WIDTH    = 16,
	parameter int TWIDDLE_WIDTH   = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic                                   cfg_index,
	input  logic [r2fft_pkg::CFG_WIDTH-1:0]        cfg_data,
	input  logic                                   start,
	output logic                                   busy,
	input  logic                                   req_type,
	input  logic signed [SAMPLE_WIDTH-1:0]         in_real,
	input  logic signed [SAMPLE_WIDTH-1:0]         in_imag,
	output logic                                   out_valid,
	output logic signed [r2fft_pkg::INNER_WIDTH-1:0] out_real,
	output logic signed [r2fft_pkg::INNER_WIDTH-1:0] out_imag,
	output logic [r2fft_pkg::BIN_WIDTH-1:0]        bin_index,
	output logic                                   bin_last
);

	localparam int AW       = MAX_POINTS_LOG2;
	localparam int DEPTH    = 1 << AW;
	localparam int LW       = $clog2(MAX_POINTS_LOG2 + 1);
	localparam int IW       = r2fft_pkg::INNER_WIDTH;
	localparam int BW       = r2fft_pkg::BIN_WIDTH;
	localparam int DW       = IW + 1;
	localparam int TW       = TWIDDLE_WIDTH;
	localparam int PW       = DW + TW;
	localparam int ROM_SIZE = (DEPTH + 1) / 2;
	localparam int RI_W     = (AW > 1) ? AW - 1 : 1;
	localparam longint HALF = longint'(1) << (TW - 2);
	localparam longint unsigned PIO4_Q60 = 64'h0C90FDAA22168C23;
	localparam longint unsigned Q60_ONE  = 64'h1000000000000000;

	typedef logic signed [TW-1:0] tw_t;
	typedef tw_t tw_tab_t [ROM_SIZE];

	function automatic longint unsigned mulq(input longint unsigned a, input longint unsigned b);
		longint unsigned ah, al, bh, bl, mid;
		ah  = a >> 32;
		al  = a & 64'hFFFFFFFF;
		bh  = b >> 32;
		bl  = b & 64'hFFFFFFFF;
		mid = ah * bl + al * bh + ((al * bl) >> 32);
		return ((ah * bh) << 4) + (mid >> 28);
	endfunction

	function automatic longint unsigned udiv(input longint unsigned num,
			input longint unsigned den);
		longint unsigned q, rem;
		q   = '0;
		rem = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[62:0], num[i]};
			if (rem >= den) begin
				rem  = rem - den;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic longint unsigned taylor(input longint unsigned x, input bit want_sin);
		longint unsigned x2, ts, ss, tc, sc;
		x2 = mulq(x, x);
		ts = x;
		ss = x;
		tc = Q60_ONE;
		sc = Q60_ONE;
		for (int k = 1; k <= 12; k++) begin
			ts = udiv(mulq(ts, x2), longint'((2 * k) * (2 * k + 1)));
			tc = udiv(mulq(tc, x2), longint'((2 * k - 1) * (2 * k)));
			if ((k & 1) == 1) begin
				ss = ss - ts;
				sc = sc - tc;
			end else begin
				ss = ss + ts;
				sc = sc + tc;
			end
		end
		return want_sin ? ss : sc;
	endfunction

	function automatic tw_t to_tw(input longint unsigned v);
		longint unsigned maxv, r;
		maxv = (longint'(1) << (TW - 1)) - 1;
		r    = (v + (longint'(1) << (60 - TW))) >> (61 - TW);
		if (r > maxv) begin
			r = maxv;
		end
		return TW'(r);
	endfunction

	function automatic tw_tab_t make_tab(input bit want_sin);
		tw_tab_t t;
		longint unsigned step, big, oct, r, s, c;
		step = PIO4_Q60 >> AW;
		for (int j = 0; j < ROM_SIZE; j++) begin
			big = longint'(j) << 3;
			oct = big >> AW;
			r   = big & longint'(DEPTH - 1);
			if (oct == 0 || oct == 2) begin
				s = taylor(step * r, 1'b1);
				c = taylor(step * r, 1'b0);
			end else begin
				s = taylor(step * (longint'(DEPTH) - r), 1'b1);
				c = taylor(step * (longint'(DEPTH) - r), 1'b0);
			end
			case (oct)
				0: t[j] = want_sin ? to_tw(s) : to_tw(c);
				1: t[j] = want_sin ? to_tw(c) : to_tw(s);
				2: t[j] = want_sin ? to_tw(c) : -to_tw(s);
				default: t[j] = want_sin ? to_tw(s) : -to_tw(c);
			endcase
		end
		return t;
	endfunction

	localparam tw_tab_t COS_TAB = make_tab(1'b0);
	localparam tw_tab_t SIN_TAB = make_tab(1'b1);

	function automatic logic [AW-1:0] rev_addr(input logic [AW-1:0] v, input logic [LW-1:0] m);
		logic [AW-1:0] r;
		r = '0;
		for (int i = 0; i < AW; i++) begin
			if (i < int'(m)) begin
				r[i] = v[int'(m) - 1 - i];
			end
		end
		return r;
	endfunction

	r2fft_pkg::st_t state_q, state_d;

	logic              inverse_mode_q;
	logic [r2fft_pkg::CFG_WIDTH-1:0] points_log2_q;
	logic              phase_q;
	logic [AW:0]       count_q;
	logic              inv_q;
	logic [LW-1:0]     m_q;
	logic [LW-1:0]     stage_q;
	logic [AW-1:0]     bf_q;

	logic [LW-1:0]     m_eff;
	logic [AW:0]       n_cur;
	logic              accept;
	logic              load_acc;
	logic              read_acc;
	logic              last_load;
	logic [AW:0]       count_inc;
	logic [AW-1:0]     rd_idx;
	logic              rd_last;

	logic [AW-1:0]     hmask;
	logic [AW-1:0]     lower;
	logic [AW-1:0]     a_addr;
	logic [AW-1:0]     b_addr;
	logic [AW-1:0]     ri_full;
	logic [RI_W-1:0]   ri;
	logic              bf_last;
	logic              conj_en;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [2*IW-1:0]   ram_wdata;
	logic [AW-1:0]     ram_raddr;
	logic [2*IW-1:0]   ram_rdata;
	logic signed [IW-1:0] rd_re, rd_im, rd_im_c;

	logic signed [IW-1:0] a_re_s1, a_im_s1;
	logic signed [IW-1:0] sum_re_s2, sum_im_s2;
	logic signed [DW-1:0] dr_s2, di_s2;
	logic signed [PW-1:0] p_rr_s3, p_ii_s3, p_ri_s3, p_ir_s3;
	tw_t                  tr_q, ti_q;
	logic signed [63:0]   bre_full, bim_full;
	logic signed [IW-1:0] bre, bim;

	logic              rd_s1;
	logic [AW-1:0]     idx_s1;
	logic              last_s1;
	logic signed [63:0] hm;
	logic signed [IW-1:0] ore, oim;
	logic              out_valid_q;
	logic signed [IW-1:0] out_real_q, out_imag_q;
	logic [BW-1:0]     bin_index_q;
	logic              bin_last_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inverse_mode_q <= 1'b0;
			points_log2_q  <= r2fft_pkg::CFG_WIDTH'(11);
		end else if (cfg_we) begin
			case (cfg_index)
				r2fft_pkg::CFG_INVERSE: inverse_mode_q <= cfg_data[0];
				r2fft_pkg::CFG_POINTS:  points_log2_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (points_log2_q == '0) begin
			m_eff = LW'(1);
		end else if (int'(points_log2_q) > AW) begin
			m_eff = LW'(AW);
		end else begin
			m_eff = LW'(points_log2_q);
		end
	end

	assign n_cur     = (AW + 1)'(1) << m_eff;
	assign busy      = (state_q != r2fft_pkg::ST_IDLE);
	assign accept    = start && !busy;
	assign load_acc  = accept && (req_type == r2fft_pkg::REQ_LOAD) &&
		(phase_q == r2fft_pkg::PHASE_LOAD);
	assign read_acc  = accept && (req_type == r2fft_pkg::REQ_READ) &&
		(phase_q == r2fft_pkg::PHASE_READ);
	assign count_inc = count_q + (AW + 1)'(1);
	assign last_load = load_acc && (count_inc >= n_cur);
	assign rd_idx    = count_q[AW-1:0];
	assign rd_last   = ((AW + 1)'(rd_idx) + (AW + 1)'(1)) >= n_cur;

	// butterfly addressing
	assign hmask   = (AW'(1) << (stage_q - LW'(1))) - AW'(1);
	assign lower   = bf_q & hmask;
	assign a_addr  = ((bf_q >> (stage_q - LW'(1))) << stage_q) | lower;
	assign b_addr  = a_addr | (AW'(1) << (stage_q - LW'(1)));
	assign ri_full = lower << (LW'(AW) - stage_q);
	assign ri      = ri_full[RI_W-1:0];
	assign bf_last = (bf_q == ((AW'(1) << (m_q - LW'(1))) - AW'(1)));
	assign conj_en = inv_q && (stage_q == m_q);

	assign rd_re   = ram_rdata[2*IW-1:IW];
	assign rd_im   = ram_rdata[IW-1:0];
	assign rd_im_c = conj_en ? r2fft_pkg::sat_inner(-64'(rd_im)) : rd_im;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			r2fft_pkg::ST_IDLE: if (last_load) begin
				state_d = r2fft_pkg::ST_RD_A;
			end
			r2fft_pkg::ST_RD_A: state_d = r2fft_pkg::ST_RD_B;
			r2fft_pkg::ST_RD_B: state_d = r2fft_pkg::ST_DIFF;
			r2fft_pkg::ST_DIFF: state_d = r2fft_pkg::ST_MUL;
			r2fft_pkg::ST_MUL:  state_d = r2fft_pkg::ST_WR_B;
			r2fft_pkg::ST_WR_B: begin
				if (bf_last && stage_q == LW'(1)) begin
					state_d = r2fft_pkg::ST_IDLE;
				end else begin
					state_d = r2fft_pkg::ST_RD_A;
				end
			end
			default: state_d = r2fft_pkg::ST_IDLE;
		endcase
	end

	// memory control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = count_q[AW-1:0];
		ram_wdata = {r2fft_pkg::sat_inner(64'(in_real)), r2fft_pkg::sat_inner(64'(in_imag))};
		ram_raddr = a_addr;
		case (state_q)
			r2fft_pkg::ST_IDLE: begin
				ram_we    = load_acc && (count_q < (AW + 1)'(DEPTH));
				ram_raddr = rev_addr(rd_idx, m_q);
			end
			r2fft_pkg::ST_RD_A: ram_raddr = a_addr;
			r2fft_pkg::ST_RD_B: ram_raddr = b_addr;
			r2fft_pkg::ST_DIFF: ram_raddr = a_addr;
			r2fft_pkg::ST_MUL: begin
				ram_we    = 1'b1;
				ram_waddr = a_addr;
				ram_wdata = {sum_re_s2, sum_im_s2};
			end
			r2fft_pkg::ST_WR_B: begin
				ram_we    = 1'b1;
				ram_waddr = b_addr;
				ram_wdata = {bre, bim};
			end
			default: ram_we = 1'b0;
		endcase
	end

	r2fft_ram #(
		.WIDTH(2 * IW),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= r2fft_pkg::ST_IDLE;
			phase_q <= r2fft_pkg::PHASE_LOAD;
			count_q <= '0;
			inv_q   <= 1'b0;
			m_q     <= LW'(AW);
			stage_q <= LW'(AW);
			bf_q    <= '0;
			rd_s1   <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_s1   <= read_acc;
			if (load_acc) begin
				if (last_load) begin
					count_q <= '0;
					phase_q <= r2fft_pkg::PHASE_READ;
					inv_q   <= inverse_mode_q;
					m_q     <= m_eff;
					stage_q <= m_eff;
					bf_q    <= '0;
				end else begin
					count_q <= count_inc;
				end
			end
			if (read_acc) begin
				if (rd_last) begin
					count_q <= '0;
					phase_q <= r2fft_pkg::PHASE_LOAD;
				end else begin
					count_q <= (AW + 1)'(rd_idx) + (AW + 1)'(1);
				end
			end
			if (state_q == r2fft_pkg::ST_WR_B) begin
				if (bf_last) begin
					bf_q    <= '0;
					stage_q <= stage_q - LW'(1);
				end else begin
					bf_q <= bf_q + AW'(1);
				end
			end
		end
	end

	// butterfly datapath
	always_ff @(posedge clk) begin
		if (state_q == r2fft_pkg::ST_RD_A) begin
			tr_q <= COS_TAB[ri];
			ti_q <= -SIN_TAB[ri];
		end
		if (state_q == r2fft_pkg::ST_RD_B) begin
			a_re_s1 <= rd_re;
			a_im_s1 <= rd_im_c;
		end
		if (state_q == r2fft_pkg::ST_DIFF) begin
			sum_re_s2 <= r2fft_pkg::sat_inner(64'(a_re_s1) + 64'(rd_re));
			sum_im_s2 <= r2fft_pkg::sat_inner(64'(a_im_s1) + 64'(rd_im_c));
			dr_s2     <= DW'(64'(a_re_s1) - 64'(rd_re));
			di_s2     <= DW'(64'(a_im_s1) - 64'(rd_im_c));
		end
		if (state_q == r2fft_pkg::ST_MUL) begin
			p_rr_s3 <= PW'(dr_s2) * PW'(tr_q);
			p_ii_s3 <= PW'(di_s2) * PW'(ti_q);
			p_ri_s3 <= PW'(dr_s2) * PW'(ti_q);
			p_ir_s3 <= PW'(di_s2) * PW'(tr_q);
		end
	end

	assign bre_full = 64'(p_rr_s3) - 64'(p_ii_s3) + 64'(HALF);
	assign bim_full = 64'(p_ri_s3) + 64'(p_ir_s3) + 64'(HALF);
	assign bre      = r2fft_pkg::sat_inner(bre_full >>> (TW - 1));
	assign bim      = r2fft_pkg::sat_inner(bim_full >>> (TW - 1));

	// output path with inverse scaling
	assign hm = 64'sd1 <<< (m_q - LW'(1));

	always_comb begin
		if (inv_q) begin
			ore = r2fft_pkg::sat_inner((64'(rd_re) + hm) >>> m_q);
			oim = r2fft_pkg::sat_inner((-64'(rd_im) + hm) >>> m_q);
		end else begin
			ore = rd_re;
			oim = rd_im;
		end
	end

	always_ff @(posedge clk) begin
		if (read_acc) begin
			idx_s1  <= rd_idx;
			last_s1 <= rd_last;
		end
		if (rd_s1) begin
			out_real_q  <= ore;
			out_imag_q  <= oim;
			bin_index_q <= BW'(idx_s1);
			bin_last_q  <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= rd_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_real  = out_real_q;
	assign out_imag  = out_imag_q;
	assign bin_index = bin_index_q;
	assign bin_last  = bin_last_q;

endmodule

// ----- rtl/core/r2fft_checker.sv -----
// port-level checks of the fft engine and their binding
module r2fft_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic req_type,
	input logic out_valid,
	input logic bin_last
);

	// every result strobe follows a read request made while not busy
	a_result_follows_read: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $past(start && !busy && req_type, 2))
		else $error("result without a read transaction");

	// no result strobe while the transform runs
	a_no_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !busy)
		else $error("result during transform");

	// the transform only starts from a load transaction
	a_busy_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && !req_type))
		else $error("transform started without a load");

	// the final bin is followed by no result in the next cycle
	a_last_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && bin_last) |=> !out_valid)
		else $error("result right after final bin");

endmodule

bind radix2_fft_engine r2fft_checker u_r2fft_checker (.*);
